### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define PHC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition at one edge brings a consequence at the next edge.
`define PHC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/phc_pkg.sv
package phc_pkg;

    localparam int COORD_W   = 32;
    localparam int T_BITS    = 32;
    localparam int MUL_W     = COORD_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int DLT_W     = MUL_W + 1;
    localparam int SUM_W     = DLT_W + 1;
    localparam int CNT_W     = $clog2(T_BITS);
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_END_X   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_END_Y   = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      final_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      point_kind;
        logic                      empty_marker;
        logic                      end_of_polygon;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } t_line;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } t_core_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_ABS,
        S_KEEP,
        S_TEST,
        S_DIV,
        S_LERP,
        S_PUSH,
        S_EDGE_END,
        S_FLUSH
    } t_state;

endpackage

### rtl/phc_cfg_regs.sv
module phc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phc_pkg::ADDR_W-1:0]    paddr,
    input  logic [phc_pkg::DATA_W-1:0]    pwdata,
    output logic [phc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output phc_pkg::t_line                o_line
);

    phc_pkg::t_line                       r_line;
    logic [phc_pkg::REG_IDX_W-1:0]        w_idx;
    logic                                 w_wr;

    assign w_idx  = paddr[phc_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_line = r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                phc_pkg::REG_START_X: r_line.px <= pwdata[phc_pkg::COORD_W-1:0];
                phc_pkg::REG_START_Y: r_line.py <= pwdata[phc_pkg::COORD_W-1:0];
                phc_pkg::REG_END_X:   r_line.qx <= pwdata[phc_pkg::COORD_W-1:0];
                phc_pkg::REG_END_Y:   r_line.qy <= pwdata[phc_pkg::COORD_W-1:0];
                default:              r_line    <= r_line;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            phc_pkg::REG_START_X: prdata = phc_pkg::DATA_W'($unsigned(r_line.px));
            phc_pkg::REG_START_Y: prdata = phc_pkg::DATA_W'($unsigned(r_line.py));
            phc_pkg::REG_END_X:   prdata = phc_pkg::DATA_W'($unsigned(r_line.qx));
            phc_pkg::REG_END_Y:   prdata = phc_pkg::DATA_W'($unsigned(r_line.qy));
            default:              prdata = '0;
        endcase
    end

endmodule

### rtl/phc_mul.sv
module phc_mul (
    input  logic                               i_clk,
    input  logic signed [phc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [phc_pkg::MUL_W-1:0]   i_b,
    output logic signed [phc_pkg::PROD_W-1:0]  o_prod
);

    logic signed [phc_pkg::PROD_W-1:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

endmodule

### rtl/phc_out_reg.sv
module phc_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  phc_pkg::t_out_item   i_item,
    input  logic                 i_stall,
    output logic                 o_valid,
    output phc_pkg::t_out_item   o_item,
    output logic                 o_slot_free
);

    logic                r_valid;
    phc_pkg::t_out_item  r_item;

    assign o_valid     = r_valid;
    assign o_item      = r_item;
    assign o_slot_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/phc_core.sv
module phc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  phc_pkg::t_line       i_line,
    input  logic                 i_valid,
    input  phc_pkg::t_in_item    i_item,
    input  logic                 i_slot_free,
    output logic                 o_push,
    output phc_pkg::t_out_item   o_result,
    output phc_pkg::t_core_stat  o_stat
);

    localparam logic [2:0] LAST_CROSS_STEP = 3'd5;
    localparam logic [2:0] LAST_LERP_STEP  = 3'd4;

    function automatic logic signed [phc_pkg::MUL_W-1:0] diff(
        input logic signed [phc_pkg::COORD_W-1:0] a,
        input logic signed [phc_pkg::COORD_W-1:0] b
    );
        return phc_pkg::MUL_W'(a) - phc_pkg::MUL_W'(b);
    endfunction

    function automatic logic signed [phc_pkg::DLT_W-1:0] shift_tz(
        input logic signed [phc_pkg::PROD_W-1:0] p
    );
        logic signed [phc_pkg::PROD_W-1:0] bias;
        logic signed [phc_pkg::PROD_W-1:0] b;
        bias = $signed({{(phc_pkg::PROD_W - phc_pkg::T_BITS){1'b0}},
                        {phc_pkg::T_BITS{1'b1}}});
        b = p[phc_pkg::PROD_W-1] ? (p + bias) : p;
        return phc_pkg::DLT_W'(b >>> phc_pkg::T_BITS);
    endfunction

    function automatic logic signed [phc_pkg::COORD_W-1:0] sat_coord(
        input logic signed [phc_pkg::SUM_W-1:0] s
    );
        logic [phc_pkg::SUM_W-phc_pkg::COORD_W:0] top;
        top = s[phc_pkg::SUM_W-1:phc_pkg::COORD_W-1];
        if ((&top) || !(|top)) begin
            return s[phc_pkg::COORD_W-1:0];
        end else if (s[phc_pkg::SUM_W-1]) begin
            return $signed({1'b1, {(phc_pkg::COORD_W-1){1'b0}}});
        end else begin
            return $signed({1'b0, {(phc_pkg::COORD_W-1){1'b1}}});
        end
    endfunction

    phc_pkg::t_state                      r_state;
    phc_pkg::t_state                      n_state;
    phc_pkg::t_state                      r_ret;
    phc_pkg::t_state                      n_ret;
    logic [2:0]                           r_step;
    logic [phc_pkg::CNT_W-1:0]            r_cnt;

    logic                                 r_have_first;
    logic                                 r_fin;
    logic                                 r_closing;
    logic signed [phc_pkg::COORD_W-1:0]   r_first_x;
    logic signed [phc_pkg::COORD_W-1:0]   r_first_y;
    logic signed [phc_pkg::COORD_W-1:0]   r_prev_x;
    logic signed [phc_pkg::COORD_W-1:0]   r_prev_y;
    logic signed [phc_pkg::COORD_W-1:0]   r_vx;
    logic signed [phc_pkg::COORD_W-1:0]   r_vy;
    logic signed [phc_pkg::COORD_W-1:0]   r_ax;
    logic signed [phc_pkg::COORD_W-1:0]   r_ay;
    logic signed [phc_pkg::COORD_W-1:0]   r_bx;
    logic signed [phc_pkg::COORD_W-1:0]   r_by;

    logic signed [phc_pkg::MUL_W-1:0]     r_ma;
    logic signed [phc_pkg::MUL_W-1:0]     r_mb;
    logic signed [phc_pkg::PROD_W-1:0]    w_prod;
    logic signed [phc_pkg::CROSS_W-1:0]   w_prod_ext;
    logic signed [phc_pkg::CROSS_W-1:0]   r_acc;
    logic signed [phc_pkg::CROSS_W-1:0]   r_num;
    logic signed [phc_pkg::CROSS_W-1:0]   r_den;
    logic [phc_pkg::CROSS_W-1:0]          r_rem;
    logic [phc_pkg::CROSS_W-1:0]          r_dv;
    logic [phc_pkg::CROSS_W-1:0]          w_rem2;
    logic [phc_pkg::CROSS_W-1:0]          w_rem_sub;
    logic                                 w_ge;
    logic                                 r_numneg;
    logic                                 r_pre;
    logic                                 w_div_go;
    logic [phc_pkg::T_BITS-1:0]           r_t;
    logic signed [phc_pkg::DLT_W-1:0]     r_dlt;

    logic signed [phc_pkg::MUL_W-1:0]     w_dx;
    logic signed [phc_pkg::MUL_W-1:0]     w_dy;
    logic signed [phc_pkg::MUL_W-1:0]     w_t_op;
    logic                                 w_accept;

    phc_pkg::t_out_item                   r_new;
    phc_pkg::t_out_item                   r_pend;
    logic                                 r_pend_v;
    logic                                 c_pend_load;
    logic                                 c_pend_clr;

    phc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_prod (w_prod)
    );

    assign w_dx       = diff(i_line.qx, i_line.px);
    assign w_dy       = diff(i_line.qy, i_line.py);
    assign w_t_op     = $signed(phc_pkg::MUL_W'(r_t));
    assign w_prod_ext = phc_pkg::CROSS_W'(w_prod);
    assign w_accept   = i_valid && (r_state == phc_pkg::S_IDLE);
    assign w_rem2     = {r_rem[phc_pkg::CROSS_W-2:0], 1'b0};
    assign w_ge       = (w_rem2 >= r_dv);
    assign w_rem_sub  = w_rem2 - r_dv;
    assign w_div_go   = r_pre && (r_rem < r_dv);

    assign o_stat.busy       = (r_state != phc_pkg::S_IDLE);
    assign o_stat.pend_valid = r_pend_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phc_pkg::S_IDLE;
            r_ret   <= phc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        o_push      = 1'b0;
        o_result    = r_pend;
        c_pend_load = 1'b0;
        c_pend_clr  = 1'b0;
        unique case (r_state)
            phc_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!r_have_first && !i_item.final_vertex) begin
                        n_state = phc_pkg::S_FLUSH;
                    end else begin
                        n_state = phc_pkg::S_CROSS;
                    end
                end
            end
            phc_pkg::S_CROSS: begin
                if (r_step == LAST_CROSS_STEP) begin
                    n_state = phc_pkg::S_ABS;
                end
            end
            phc_pkg::S_ABS: begin
                n_state = phc_pkg::S_KEEP;
            end
            phc_pkg::S_KEEP: begin
                if (!r_numneg) begin
                    n_state = phc_pkg::S_PUSH;
                    n_ret   = phc_pkg::S_TEST;
                end else begin
                    n_state = phc_pkg::S_TEST;
                end
            end
            phc_pkg::S_TEST: begin
                n_state = w_div_go ? phc_pkg::S_DIV : phc_pkg::S_EDGE_END;
            end
            phc_pkg::S_DIV: begin
                if (r_cnt == phc_pkg::CNT_W'(phc_pkg::T_BITS - 1)) begin
                    n_state = phc_pkg::S_LERP;
                end
            end
            phc_pkg::S_LERP: begin
                if (r_step == LAST_LERP_STEP) begin
                    n_state = phc_pkg::S_PUSH;
                    n_ret   = phc_pkg::S_EDGE_END;
                end
            end
            phc_pkg::S_PUSH: begin
                if (!r_pend_v) begin
                    c_pend_load = 1'b1;
                    n_state     = r_ret;
                end else if (i_slot_free) begin
                    o_push      = 1'b1;
                    c_pend_load = 1'b1;
                    n_state     = r_ret;
                end
            end
            phc_pkg::S_EDGE_END: begin
                if (r_fin && !r_closing) begin
                    n_state = phc_pkg::S_CROSS;
                end else begin
                    n_state = phc_pkg::S_FLUSH;
                end
            end
            phc_pkg::S_FLUSH: begin
                if (r_fin) begin
                    if (i_slot_free) begin
                        o_push = 1'b1;
                        if (r_pend_v) begin
                            o_result.end_of_polygon = 1'b1;
                        end else begin
                            o_result                = '0;
                            o_result.empty_marker   = 1'b1;
                            o_result.end_of_polygon = 1'b1;
                        end
                        c_pend_clr = 1'b1;
                        n_state    = phc_pkg::S_IDLE;
                    end
                end else if (!r_pend_v) begin
                    n_state = phc_pkg::S_IDLE;
                end else if (i_slot_free) begin
                    o_push     = 1'b1;
                    c_pend_clr = 1'b1;
                    n_state    = phc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_pend_v     <= 1'b0;
        end else begin
            if (w_accept && !r_have_first) begin
                r_have_first <= 1'b1;
            end else if (c_pend_clr && r_fin) begin
                r_have_first <= 1'b0;
            end
            if (c_pend_clr) begin
                r_pend_v <= 1'b0;
            end else if (c_pend_load) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_pend_load) begin
            r_pend <= r_new;
        end
        unique case (r_state)
            phc_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_vx      <= i_item.vertex_x;
                    r_vy      <= i_item.vertex_y;
                    r_fin     <= i_item.final_vertex;
                    r_prev_x  <= i_item.vertex_x;
                    r_prev_y  <= i_item.vertex_y;
                    r_step    <= '0;
                    r_closing <= !r_have_first;
                    r_bx      <= i_item.vertex_x;
                    r_by      <= i_item.vertex_y;
                    if (r_have_first) begin
                        r_ax <= r_prev_x;
                        r_ay <= r_prev_y;
                    end else begin
                        r_ax      <= i_item.vertex_x;
                        r_ay      <= i_item.vertex_y;
                        r_first_x <= i_item.vertex_x;
                        r_first_y <= i_item.vertex_y;
                    end
                end
            end
            phc_pkg::S_CROSS: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        r_ma <= w_dx;
                        r_mb <= diff(r_ay, i_line.py);
                    end
                    3'd1: begin
                        r_ma <= w_dy;
                        r_mb <= diff(r_ax, i_line.px);
                    end
                    3'd2: begin
                        r_acc <= w_prod_ext;
                        r_ma  <= w_dx;
                        r_mb  <= diff(r_ay, r_by);
                    end
                    3'd3: begin
                        r_num <= r_acc - w_prod_ext;
                        r_ma  <= w_dy;
                        r_mb  <= diff(r_ax, r_bx);
                    end
                    3'd4: begin
                        r_acc <= w_prod_ext;
                    end
                    default: begin
                        r_den <= r_acc - w_prod_ext;
                    end
                endcase
            end
            phc_pkg::S_ABS: begin
                r_rem    <= r_num[phc_pkg::CROSS_W-1] ? $unsigned(-r_num) : $unsigned(r_num);
                r_dv     <= r_den[phc_pkg::CROSS_W-1] ? $unsigned(-r_den) : $unsigned(r_den);
                r_numneg <= r_num[phc_pkg::CROSS_W-1];
                r_pre    <= (r_den != '0) && (r_num != '0)
                            && (r_num[phc_pkg::CROSS_W-1] == r_den[phc_pkg::CROSS_W-1]);
            end
            phc_pkg::S_KEEP: begin
                r_new.out_x          <= r_ax;
                r_new.out_y          <= r_ay;
                r_new.point_kind     <= 1'b0;
                r_new.empty_marker   <= 1'b0;
                r_new.end_of_polygon <= 1'b0;
            end
            phc_pkg::S_TEST: begin
                r_cnt <= '0;
                r_t   <= '0;
            end
            phc_pkg::S_DIV: begin
                r_cnt  <= r_cnt + phc_pkg::CNT_W'(1);
                r_rem  <= w_ge ? w_rem_sub : w_rem2;
                r_t    <= {r_t[phc_pkg::T_BITS-2:0], w_ge};
                r_step <= '0;
            end
            phc_pkg::S_LERP: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        r_ma <= w_t_op;
                        r_mb <= diff(r_bx, r_ax);
                    end
                    3'd1: begin
                        r_ma <= w_t_op;
                        r_mb <= diff(r_by, r_ay);
                    end
                    3'd2: begin
                        r_dlt <= shift_tz(w_prod);
                    end
                    3'd3: begin
                        r_new.out_x <= sat_coord(phc_pkg::SUM_W'(r_ax)
                                                 + phc_pkg::SUM_W'(r_dlt));
                        r_dlt       <= shift_tz(w_prod);
                    end
                    default: begin
                        r_new.out_y          <= sat_coord(phc_pkg::SUM_W'(r_ay)
                                                          + phc_pkg::SUM_W'(r_dlt));
                        r_new.point_kind     <= 1'b1;
                        r_new.empty_marker   <= 1'b0;
                        r_new.end_of_polygon <= 1'b0;
                    end
                endcase
            end
            phc_pkg::S_EDGE_END: begin
                if (r_fin && !r_closing) begin
                    r_ax      <= r_vx;
                    r_ay      <= r_vy;
                    r_bx      <= r_first_x;
                    r_by      <= r_first_y;
                    r_closing <= 1'b1;
                    r_step    <= '0;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

endmodule

### rtl/polygon_halfplane_clip.sv
// The input stalls while an item is processed. Each edge that the item closes runs the cross
// products; an edge that crosses the line also runs the 32-step divider and the interpolation.
// A final vertex also handles the edge that closes the polygon back to the first vertex;
// output stalls can hold an item longer still.
// Synchronous active-low reset clears the sequencer, the output valid and the line
// registers (to zero), and starts a new polygon.
`include "assert_macros.svh"

module polygon_halfplane_clip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  phc_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output phc_pkg::t_out_item            o_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phc_pkg::ADDR_W-1:0]    paddr,
    input  logic [phc_pkg::DATA_W-1:0]    pwdata,
    output logic [phc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    phc_pkg::t_line       w_line;
    phc_pkg::t_out_item   w_result;
    phc_pkg::t_core_stat  w_stat;
    logic                 w_push;
    logic                 w_slot_free;
    logic                 w_marker_ok;

    phc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_line  (w_line)
    );

    phc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_line      (w_line),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .i_slot_free (w_slot_free),
        .o_push      (w_push),
        .o_result    (w_result),
        .o_stat      (w_stat)
    );

    phc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_result),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .o_slot_free (w_slot_free)
    );

    assign o_stall = w_stat.busy;

    assign w_marker_ok = !(o_valid && o_item.empty_marker)
                         || (o_item.end_of_polygon && !o_item.point_kind
                             && (o_item.out_x == '0) && (o_item.out_y == '0));

    `PHC_ASSERT(a_idle_no_pending, !w_stat.busy |-> !w_stat.pend_valid, "result pending while idle")
    `PHC_ASSERT(a_marker_form, w_marker_ok, "malformed empty marker")
    `PHC_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "idle after taking an item")

endmodule
